// ===== rtl/core/in_order_response_reorder_macros.svh =====
// Assertion macros used by the checker file.
`ifndef IN_ORDER_RESPONSE_REORDER_MACROS_SVH
`define IN_ORDER_RESPONSE_REORDER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ORR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("orr assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define ORR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	`ORR_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== rtl/core/orr_pkg.sv =====
package orr_pkg;

	// Default reorder window, in slots.
	localparam int WINDOW_DEF = 16;

	// Size of the sequence number space; the all-ones number is out of range.
	localparam logic [31:0] SEQ_SPACE = 32'hffff_ffff;
	localparam logic [31:0] SEQ_LAST  = 32'hffff_fffe;

	// Request kinds.
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_OTHER = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] seq_num;
		logic [15:0] client_tag;
		logic [31:0] payload_ref;
		logic [13:0] payload_len;
	} cpl_word_t;

	typedef struct packed {
		logic [15:0] out_tag;
		logic [31:0] out_ref;
		logic [13:0] out_len;
		logic [31:0] out_seq;
		logic        dropped;
		logic        last;
	} rsp_word_t;

	// Held completion: tag, ref, len.
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] pref;
		logic [13:0] len;
	} slot_entry_t;

endpackage

// ===== rtl/core/orr_ram.sv =====
module orr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry; read registered, held while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/in_order_response_reorder.sv =====
// Channel | Direction | Handshake            | Word
// cpl     | in        | cpl_valid, cpl_stall | cpl_word_t: one completed request
// rsp     | out       | rsp_valid, rsp_stall | rsp_word_t: one released response
//
// A completion is taken in one cycle and evaluated in the next, so a new item
// is not taken until the last is done; a match then drains one held slot per
// cycle through the slot RAM read port while the response is not stalled.
// Reset clears the expected counter and all slot valid bits at once.
// A stalled response holds the engine in place; new completions are stalled
// while an item is being evaluated or drained.
module in_order_response_reorder
	import orr_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cpl_valid,
	output logic      cpl_stall,
	input  cpl_word_t cpl,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int IW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [31:0] WIN32 = 32'(WINDOW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DRAIN
	} state_t;

	state_t          state_q;
	cpl_word_t       cpl_q;
	logic [31:0]     exp_q;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   cnt_q;
	logic [WINDOW-1:0] valid_q;
	logic            out_valid_q;
	rsp_word_t       out_q;

	logic [32:0]     diff;
	logic            borrow;
	logic [31:0]     wdist;
	logic            far;
	logic            match;
	logic [IW:0]     idx_sum;
	logic [IW:0]     idx_adj;
	logic [IW-1:0]   early_idx;
	logic [31:0]     exp_nxt;
	logic [IW-1:0]   idx_nxt;
	logic [CW-1:0]   cnt_inc;
	logic            more;
	logic            free;
	logic            emit;
	logic            ram_we;
	logic            ram_re;
	slot_entry_t     wr_entry;
	slot_entry_t     rd_entry;

	// Distance of the held completion from the expected number.
	always_comb begin
		diff   = {1'b0, cpl_q.seq_num} - {1'b0, exp_q};
		borrow = diff[32];
		wdist  = cpl_q.seq_num + ~exp_q;
		far    = (cpl_q.seq_num == SEQ_SPACE) ||
			(borrow ? (wdist >= WIN32) : (diff[31:0] >= WIN32));
		match  = !far && !borrow && (diff[31:0] == 32'd0);
	end

	// Slot of an early read: expected slot plus distance, wrapped at the window, or the
	// low bits of the number itself when the read lies past the wrap.
	always_comb begin
		idx_sum = {1'b0, idx_q} + {1'b0, diff[IW-1:0]};
		idx_adj = idx_sum - (IW+1)'(WINDOW);
		if (borrow) begin
			early_idx = cpl_q.seq_num[IW-1:0];
		end else if (idx_sum >= (IW+1)'(WINDOW)) begin
			early_idx = idx_adj[IW-1:0];
		end else begin
			early_idx = idx_sum[IW-1:0];
		end
	end

	// Advance the expected number and its slot, and see whether another held slot follows.
	always_comb begin
		if (exp_q == SEQ_LAST) begin
			exp_nxt = 32'd0;
			idx_nxt = '0;
		end else begin
			exp_nxt = exp_q + 32'd1;
			idx_nxt = (idx_q == IW'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
		end
		cnt_inc = (state_q == ST_EVAL) ? CW'(1) : cnt_q + 1'b1;
		more    = valid_q[idx_nxt] && (cnt_inc != CW'(WINDOW));
	end

	assign free      = !out_valid_q || !rsp_stall;
	assign cpl_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Load a new response word this cycle.
	assign emit = free && (((state_q == ST_EVAL) && (cpl_q.func == FUNC_READ)
		&& (far || match)) || (state_q == ST_DRAIN));

	assign ram_we = (state_q == ST_EVAL) && (cpl_q.func == FUNC_READ) && !far && !match;
	assign ram_re = free && more && (((state_q == ST_EVAL) && (cpl_q.func == FUNC_READ)
		&& match) || (state_q == ST_DRAIN));
	assign wr_entry = '{tag: cpl_q.client_tag, pref: cpl_q.payload_ref,
		len: cpl_q.payload_len};

	orr_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(WINDOW)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (early_idx),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (idx_nxt),
		.rdata (rd_entry)
	);

	// Hold state and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !rsp_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			if (ram_re) begin
				valid_q[idx_nxt] <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cpl_valid) begin
						cpl_q   <= cpl;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (cpl_q.func != FUNC_READ) begin
						state_q <= ST_IDLE;
					end else if (!far && !match) begin
						valid_q[early_idx] <= 1'b1;
						state_q            <= ST_IDLE;
					end else if (free) begin
						out_valid_q   <= 1'b1;
						out_q.out_tag <= cpl_q.client_tag;
						out_q.out_ref <= cpl_q.payload_ref;
						out_q.out_len <= cpl_q.payload_len;
						if (far) begin
							out_q.out_seq <= cpl_q.seq_num;
							out_q.dropped <= 1'b1;
							out_q.last    <= 1'b1;
							state_q       <= ST_IDLE;
						end else begin
							out_q.out_seq <= exp_q;
							out_q.dropped <= 1'b0;
							out_q.last    <= !more;
							exp_q         <= exp_nxt;
							idx_q         <= idx_nxt;
							cnt_q         <= cnt_inc;
							state_q       <= more ? ST_DRAIN : ST_IDLE;
						end
					end
				end
				ST_DRAIN: begin
					if (free) begin
						out_valid_q   <= 1'b1;
						out_q.out_tag <= rd_entry.tag;
						out_q.out_ref <= rd_entry.pref;
						out_q.out_len <= rd_entry.len;
						out_q.out_seq <= exp_q;
						out_q.dropped <= 1'b0;
						out_q.last    <= !more;
						exp_q         <= exp_nxt;
						idx_q         <= idx_nxt;
						cnt_q         <= cnt_inc;
						state_q       <= more ? ST_DRAIN : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/orr_checker.sv =====
`include "in_order_response_reorder_macros.svh"

module orr_checker
	import orr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cpl_valid,
	input logic      cpl_stall,
	input cpl_word_t cpl,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_word_t rsp
);

	// Hold a stalled response word.
	`ORR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// A dropped word always ends its item.
	`ORR_ASSERT(a_drop_last, clk, arst_n, rsp_valid |-> (!rsp.dropped || rsp.last))

	// Stall the next word while an accepted one is evaluated.
	`ORR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cpl_valid && !cpl_stall, cpl_stall)

	// Stall completions while a drain is still under way.
	`ORR_ASSERT(a_drain_blocks, clk, arst_n, (rsp_valid && !rsp.last) |-> cpl_stall)

endmodule

bind in_order_response_reorder orr_checker u_orr_checker (.*);
